### sv/tcep_pkg.sv
// shared constants, character codes, state and command types for the text cursor parser
// no dependencies; imported by tcep_ctrl, tcep_datapath and the top level
package tcep_pkg;

  // screen geometry; cursor values are 16 bits wide, edge comparisons use 17 bits
  localparam logic [15:0] SCREEN_W = 16'd240;
  localparam logic [15:0] SCREEN_H = 16'd320;
  localparam logic [15:0] GLYPH_W  = 16'd8;
  localparam logic [15:0] GLYPH_H  = 16'd12;
  localparam logic [15:0] ROW_GAP  = 16'd2;
  localparam logic [15:0] ROW_STEP = GLYPH_H + ROW_GAP;

  // lookahead buffer depth and color packing
  localparam int HOLD_MAX    = 7;
  localparam int RED_SHIFT   = 11;
  localparam int GREEN_SHIFT = 5;

  // character codes
  localparam logic [7:0] CH_S     = 8'h53;
  localparam logic [7:0] CH_B     = 8'h42;
  localparam logic [7:0] CH_C     = 8'h43;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // result kinds
  localparam logic CMD_DRAW = 1'b0;
  localparam logic CMD_FILL = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_REPLAY,
    ST_FILL
  } state_t;

  // action taken on the accepted character
  typedef enum logic [2:0] {
    OP_NONE,
    OP_HOLD,
    OP_STORE_REPLAY,
    OP_REHOLD_REPLAY,
    OP_COLOR
  } op_t;

  typedef struct packed {
    op_t  op;
    logic step;
    logic fill;
  } cmd_t;

  typedef struct packed {
    logic [2:0] count;
    logic       in_sb;
    logic       in_c;
    logic       in_last;
    logic       held_b;
    logic       at_end;
    logic       stall;
    logic       out_free;
  } status_t;

endpackage

### sv/tcep_ctrl.sv
// controller state machine: classifies each accepted character and sequences replay and fill
// depends on tcep_pkg
module tcep_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  tcep_pkg::status_t status,
  output tcep_pkg::cmd_t    cmd
);
  import tcep_pkg::*;

  state_t state, state_next;
  op_t    accept_op;
  logic   accept;

  // decide what the accepted character does
  always_comb begin
    accept    = in_valid && (state == ST_IDLE);
    accept_op = OP_NONE;
    if (accept) begin
      priority if (status.count == 3'd0) begin
        accept_op = (status.in_sb && !status.in_last) ? OP_HOLD : OP_STORE_REPLAY;
      end else if (status.count == 3'd1 && !status.in_c) begin
        accept_op = (status.in_sb && !status.in_last) ? OP_REHOLD_REPLAY : OP_STORE_REPLAY;
      end else if (status.count == 3'(HOLD_MAX)) begin
        accept_op = OP_COLOR;
      end else begin
        accept_op = status.in_last ? OP_STORE_REPLAY : OP_HOLD;
      end
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept_op == OP_STORE_REPLAY || accept_op == OP_REHOLD_REPLAY) begin
          state_next = ST_REPLAY;
        end else if (accept_op == OP_COLOR && status.held_b) begin
          state_next = ST_FILL;
        end
      end
      ST_REPLAY: begin
        if (!status.stall && status.at_end) state_next = ST_IDLE;
      end
      ST_FILL: begin
        if (status.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready = (state == ST_IDLE);
    cmd.op   = accept_op;
    cmd.step = (state == ST_REPLAY);
    cmd.fill = (state == ST_FILL);
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

### sv/tcep_datapath.sv
// datapath: cursor and color registers, lookahead buffer, draw unit and output register
// depends on tcep_pkg; driven by tcep_ctrl commands
module tcep_datapath (
  input  logic              clk,
  input  logic              rst,
  input  tcep_pkg::cmd_t    cmd,
  output tcep_pkg::status_t status,
  input  logic [7:0]        in_char,
  input  logic              in_last,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_command,
  output logic [7:0]        out_glyph,
  output logic [9:0]        out_pos_x,
  output logic [9:0]        out_pos_y,
  output logic [15:0]       out_fore,
  output logic [15:0]       out_back,
  output logic              out_last
);
  import tcep_pkg::*;

  logic [15:0] column_pos, row_pos, text_color, fill_color;
  logic [7:0]  lookahead_chars [HOLD_MAX];
  logic [2:0]  lookahead_count;
  logic [2:0]  replay_idx, replay_end;
  logic        rehold;

  logic [7:0]  cur_char;
  logic [7:0]  red, green, blue;
  logic [15:0] new_color;
  logic [15:0] row_adv, col_a, row_a, row_b, col_n, row_n;
  logic        col_wrap, draw, later_draw;
  logic        out_free, stall, advance, out_load, at_end, store_we;
  logic [2:0]  store_idx;

  // two-character decimal field, atoi rules, modulo 256
  function automatic logic [7:0] field_value(input logic [7:0] a, input logic [7:0] b);
    logic       a_dig, b_dig;
    logic [7:0] da, db, v;
    a_dig = (a >= CH_ZERO) && (a <= CH_NINE);
    b_dig = (b >= CH_ZERO) && (b <= CH_NINE);
    da    = a - CH_ZERO;
    db    = b - CH_ZERO;
    v     = 8'h00;
    if (a_dig) begin
      v = b_dig ? (da * 8'd10 + db) : da;
    end else if (a == CH_SPACE || (a >= CH_TAB && a <= CH_CR) || a == CH_PLUS) begin
      v = b_dig ? db : 8'h00;
    end else if (a == CH_MINUS) begin
      v = b_dig ? (8'h00 - db) : 8'h00;
    end
    return v;
  endfunction

  // color from the five buffered field characters and the closing one
  always_comb begin
    red       = field_value(lookahead_chars[2], lookahead_chars[3]);
    green     = field_value(lookahead_chars[4], lookahead_chars[5]);
    blue      = field_value(lookahead_chars[6], in_char);
    new_color = ({8'h00, red} << RED_SHIFT) | ({8'h00, green} << GREEN_SHIFT)
              | {8'h00, blue};
  end

  // cursor update for the character under replay
  always_comb begin
    cur_char = lookahead_chars[replay_idx];
    row_adv  = row_pos + ROW_STEP;
    col_wrap = ({1'b0, column_pos} + {1'b0, GLYPH_W}) > {1'b0, SCREEN_W};
    col_a    = col_wrap ? 16'h0000 : column_pos;
    row_a    = col_wrap ? row_adv : row_pos;
    row_b    = (({1'b0, row_a} + {1'b0, GLYPH_H}) > {1'b0, SCREEN_H}) ? 16'h0000 : row_a;
    draw     = 1'b0;
    col_n    = column_pos;
    row_n    = row_pos;
    priority if (cur_char == CH_LF) begin
      col_n = 16'h0000;
      row_n = row_adv;
    end else if (cur_char == CH_CR) begin
      col_n = 16'h0000;
    end else begin
      draw  = 1'b1;
      col_n = col_a + GLYPH_W;
      row_n = row_b;
    end
  end

  // does any later replayed character still draw
  always_comb begin
    later_draw = 1'b0;
    for (int j = 0; j < HOLD_MAX; j++) begin
      if (3'(j) > replay_idx && 3'(j) <= replay_end &&
          lookahead_chars[3'(j)] != CH_LF && lookahead_chars[3'(j)] != CH_CR) begin
        later_draw = 1'b1;
      end
    end
  end

  // handshake and step control
  always_comb begin
    out_free  = !out_valid || out_ready;
    stall     = cmd.step && draw && !out_free;
    advance   = cmd.step && !stall;
    out_load  = (advance && draw) || (cmd.fill && out_free);
    at_end    = (replay_idx == replay_end);
    store_we  = (cmd.op == OP_HOLD) || (cmd.op == OP_STORE_REPLAY) ||
                (cmd.op == OP_REHOLD_REPLAY);
    store_idx = (cmd.op == OP_REHOLD_REPLAY) ? 3'd1 : lookahead_count;
  end

  // status to the controller
  always_comb begin
    status.count    = lookahead_count;
    status.in_sb    = (in_char == CH_S) || (in_char == CH_B);
    status.in_c     = (in_char == CH_C);
    status.in_last  = in_last;
    status.held_b   = (lookahead_chars[0] == CH_B);
    status.at_end   = at_end;
    status.stall    = stall;
    status.out_free = out_free;
  end

  // control and cursor state
  always_ff @(posedge clk) begin
    if (rst) begin
      column_pos      <= 16'h0000;
      row_pos         <= 16'h0000;
      text_color      <= 16'h0000;
      fill_color      <= 16'h0000;
      lookahead_count <= 3'd0;
      replay_idx      <= 3'd0;
      replay_end      <= 3'd0;
      rehold          <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (cmd.op)
        OP_HOLD: begin
          lookahead_count <= lookahead_count + 3'd1;
        end
        OP_STORE_REPLAY: begin
          lookahead_count <= 3'd0;
          replay_idx      <= 3'd0;
          replay_end      <= lookahead_count;
          rehold          <= 1'b0;
        end
        OP_REHOLD_REPLAY: begin
          lookahead_count <= 3'd0;
          replay_idx      <= 3'd0;
          replay_end      <= 3'd0;
          rehold          <= 1'b1;
        end
        OP_COLOR: begin
          lookahead_count <= 3'd0;
          if (lookahead_chars[0] == CH_B) begin
            fill_color <= new_color;
          end else begin
            text_color <= new_color;
          end
        end
        default: ;
      endcase
      if (advance) begin
        column_pos <= col_n;
        row_pos    <= row_n;
        replay_idx <= replay_idx + 3'd1;
        if (at_end && rehold) begin
          lookahead_count <= 3'd1;
          rehold          <= 1'b0;
        end
      end
    end
  end

  // lookahead buffer, no reset
  always_ff @(posedge clk) begin
    if (store_we) lookahead_chars[store_idx] <= in_char;
    if (advance && at_end && rehold) lookahead_chars[0] <= lookahead_chars[1];
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_command <= cmd.fill ? CMD_FILL : CMD_DRAW;
      out_glyph   <= cmd.fill ? 8'h00 : cur_char;
      out_pos_x   <= cmd.fill ? 10'd0 : col_a[9:0];
      out_pos_y   <= cmd.fill ? 10'd0 : row_b[9:0];
      out_fore    <= text_color;
      out_back    <= fill_color;
      out_last    <= cmd.fill ? 1'b1 : !later_draw;
    end
  end

`ifndef SYNTHESIS
  a_replay_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.step |-> (replay_idx <= replay_end))
    else $error("replay index passed the end of the buffered run");

  a_color_clears: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_COLOR) |=> (lookahead_count == 3'd0))
    else $error("lookahead not cleared after a color sequence");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_load |-> (!out_valid || out_ready))
    else $error("output register overwritten before its transaction");

  a_rehold_count: assert property (@(posedge clk) disable iff (rst)
    (advance && at_end && rehold) |=> (lookahead_count == 3'd1))
    else $error("held character not restored after replay");
`endif

endmodule

### sv/text_cursor_escape_parser_unit.sv
// top level of the text cursor and escape sequence parser
// depends on tcep_pkg, tcep_ctrl and tcep_datapath
//
//  channel   direction  tdata                          tuser    tlast
//  s_axis    in         character[7:0]                 -        end_of_string
//  m_axis    out        glyph,pos_x,pos_y,fore,back    command  last_of_run
//
// an ordinary character is accepted, then takes one draw-unit step
// a held character of a sequence, or a color sequence close, needs only the accept; BC adds a fill step
// a string end inside a sequence replays every buffered character, the ending one included
// a draw or fill step waits while the output register holds an untaken result
// rst is synchronous; cursor, colors and lookahead count clear to zero
module text_cursor_escape_parser_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] character
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // glyph, pos_x, pos_y, fore_color, back_color, zero pad
  output logic        m_axis_tuser,   // [0] command
  output logic        m_axis_tlast
);
  import tcep_pkg::*;

  cmd_t        cmd;
  status_t     status;
  logic [7:0]  glyph;
  logic [9:0]  pos_x, pos_y;
  logic [15:0] fore_color, back_color;

  // controller
  tcep_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // datapath
  tcep_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .in_char     (s_axis_tdata),
    .in_last     (s_axis_tlast),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .out_command (m_axis_tuser),
    .out_glyph   (glyph),
    .out_pos_x   (pos_x),
    .out_pos_y   (pos_y),
    .out_fore    (fore_color),
    .out_back    (back_color),
    .out_last    (m_axis_tlast)
  );

  // pack result fields, glyph in the lowest bits and zero pad on top
  assign m_axis_tdata = {4'h0, back_color, fore_color, pos_y, pos_x, glyph};

endmodule

### tb/tcep_checker.sv
// result checker for the text cursor parser: predicts every result from the accepted
// characters and compares the results taken on the output channel; depends on tcep_pkg
`timescale 1ns / 100ps

module tcep_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] character
  input  logic        s_axis_tlast,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [63:0] m_axis_tdata,   // glyph, pos_x, pos_y, fore_color, back_color, zero pad
  input  logic        m_axis_tuser,   // [0] command
  input  logic        m_axis_tlast,
  output int          fail_count,
  output int          pending
);
  import tcep_pkg::*;

  typedef struct packed {
    logic        cmd;
    logic [7:0]  glyph;
    logic [9:0]  pos_x;
    logic [9:0]  pos_y;
    logic [15:0] fore;
    logic [15:0] back;
    logic        last;
  } draw_cmd_t;

  // predicted draw and fill commands, oldest first
  draw_cmd_t   draw_cmd_q[$];

  // predicted cursor, colors and lookahead buffer
  logic [15:0] cur_col;
  logic [15:0] cur_row;
  logic [15:0] text_col;
  logic [15:0] fill_col;
  logic [7:0]  held [HOLD_MAX];
  int unsigned held_n;

  int          n_bad = 0;

  assign fail_count = n_bad;

  function automatic logic is_dig(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_ws(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  // two-character decimal field with leading blank, sign, or no digits at all
  function automatic logic [7:0] field_val(input logic [7:0] a, input logic [7:0] b);
    int v;
    v = 0;
    if (is_dig(a)) begin
      v = int'(a) - int'(CH_ZERO);
      if (is_dig(b)) v = v * 10 + (int'(b) - int'(CH_ZERO));
    end else if (is_ws(a) || (a == CH_PLUS)) begin
      if (is_dig(b)) v = int'(b) - int'(CH_ZERO);
    end else if (a == CH_MINUS) begin
      if (is_dig(b)) v = -(int'(b) - int'(CH_ZERO));
    end
    return v[7:0];
  endfunction

  task automatic put_result(input logic cmd, input logic [7:0] glyph);
    draw_cmd_t rec;
    rec.cmd   = cmd;
    rec.glyph = glyph;
    rec.pos_x = (cmd == CMD_FILL) ? 10'd0 : cur_col[9:0];
    rec.pos_y = (cmd == CMD_FILL) ? 10'd0 : cur_row[9:0];
    rec.fore  = text_col;
    rec.back  = fill_col;
    rec.last  = 1'b0;
    draw_cmd_q.push_back(rec);
  endtask

  // newline, carriage return, or a glyph drawn with edge wrap
  task automatic draw_plain(input logic [7:0] c);
    if (c == CH_LF) begin
      cur_col = '0;
      cur_row = cur_row + ROW_STEP;
    end else if (c == CH_CR) begin
      cur_col = '0;
    end else begin
      if (int'(cur_col) + int'(GLYPH_W) > int'(SCREEN_W)) begin
        cur_col = '0;
        cur_row = cur_row + ROW_STEP;
      end
      if (int'(cur_row) + int'(GLYPH_H) > int'(SCREEN_H)) cur_row = '0;
      put_result(CMD_DRAW, c);
      cur_col = cur_col + GLYPH_W;
    end
  endtask

  // an S or B that is not the last character opens a possible sequence
  task automatic start_char(input logic [7:0] c, input logic eos);
    if (((c == CH_S) || (c == CH_B)) && !eos) begin
      held[0] = c;
      held_n  = 1;
    end else begin
      draw_plain(c);
    end
  endtask

  task automatic parse_char(input logic [7:0] c, input logic eos);
    int          n0;
    int unsigned cnt;
    logic [7:0]  r, g, b;
    logic [31:0] color;
    draw_cmd_t   tail;
    n0 = draw_cmd_q.size();
    if (held_n == 0) begin
      start_char(c, eos);
    end else if ((held_n == 1) && (c != CH_C)) begin
      // not a sequence after all: draw the held character, then treat this one afresh
      held_n = 0;
      draw_plain(held[0]);
      start_char(c, eos);
    end else if (held_n == HOLD_MAX) begin
      // eighth character closes the sequence
      r = field_val(held[2], held[3]);
      g = field_val(held[4], held[5]);
      b = field_val(held[6], c);
      color = ({24'd0, r} << RED_SHIFT) | ({24'd0, g} << GREEN_SHIFT) | {24'd0, b};
      held_n = 0;
      if (held[0] == CH_S) begin
        text_col = color[15:0];
      end else begin
        fill_col = color[15:0];
        put_result(CMD_FILL, 8'd0);
      end
    end else begin
      held[3'(held_n)] = c;
      held_n++;
      // string ended inside a sequence: replay everything held
      if (eos) begin
        cnt    = held_n;
        held_n = 0;
        for (int k = 0; k < cnt; k++) draw_plain(held[3'(k)]);
      end
    end
    if (draw_cmd_q.size() > n0) begin
      tail      = draw_cmd_q.pop_back();
      tail.last = 1'b1;
      draw_cmd_q.push_back(tail);
    end
  endtask

  // predict on input transactions, compare on output transactions
  always @(posedge clk) begin : monitor
    draw_cmd_t got;
    draw_cmd_t want;
    if (rst) begin
      cur_col  = '0;
      cur_row  = '0;
      text_col = '0;
      fill_col = '0;
      held_n   = 0;
      draw_cmd_q.delete();
      pending <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) parse_char(s_axis_tdata, s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready) begin
        got.cmd   = m_axis_tuser;
        got.glyph = m_axis_tdata[7:0];
        got.pos_x = m_axis_tdata[17:8];
        got.pos_y = m_axis_tdata[27:18];
        got.fore  = m_axis_tdata[43:28];
        got.back  = m_axis_tdata[59:44];
        got.last  = m_axis_tlast;
        if (draw_cmd_q.size() == 0) begin
          $display("%0t: unexpected result cmd %0d glyph %h x %0d y %0d fg %h bg %h last %0d",
                   $time, got.cmd, got.glyph, got.pos_x, got.pos_y, got.fore, got.back,
                   got.last);
          n_bad++;
        end else begin
          want = draw_cmd_q.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch expected cmd %0d glyph %h x %0d y %0d fg %h bg %h last %0d",
                     $time, want.cmd, want.glyph, want.pos_x, want.pos_y, want.fore,
                     want.back, want.last);
            $display("%0t:          actual cmd %0d glyph %h x %0d y %0d fg %h bg %h last %0d",
                     $time, got.cmd, got.glyph, got.pos_x, got.pos_y, got.fore, got.back,
                     got.last);
            n_bad++;
          end
        end
      end
      pending <= draw_cmd_q.size();
    end
  end

endmodule

### tb/tb_top.sv
// testbench top for text_cursor_escape_parser_unit: clock, reset, character strings and
// output back-pressure; depends on tcep_pkg, the block and tcep_checker
`timescale 1ns / 100ps

module tb_top;
  import tcep_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'd0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;
  logic        m_tuser;
  logic        m_tlast;

  // no random idling on either side while set
  logic        calm = 1'b0;
  int          n_sent = 0;
  int          fail_count;
  int          pending;

  text_cursor_escape_parser_unit u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tlast  (s_tlast),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .m_axis_tuser  (m_tuser),
    .m_axis_tlast  (m_tlast)
  );

  tcep_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tlast  (s_tlast),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .m_axis_tuser  (m_tuser),
    .m_axis_tlast  (m_tlast),
    .fail_count    (fail_count),
    .pending       (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // run limit
  initial begin
    #400000;
    $display("FAILURE");
    $finish;
  end

  // output back-pressure
  always @(posedge clk) begin
    if (calm) begin
      m_tready <= 1'b1;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= 20);
    end
  end

  // one character transaction, with random idle cycles ahead of it
  task automatic send_char(input logic [7:0] c, input logic eos);
    while (!calm && ($urandom_range(0, 99) < 20)) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= c;
    s_tlast  <= eos;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    n_sent++;
  endtask

  task automatic send_text(input string txt);
    for (int k = 0; k < txt.len(); k++) send_char(txt[k], k == txt.len() - 1);
  endtask

  // mostly digits, some blanks, signs and arbitrary bytes
  function automatic logic [7:0] field_char();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return CH_ZERO + 8'($urandom_range(0, 9));
      5:             return CH_SPACE;
      6:             return CH_TAB + 8'($urandom_range(0, 4));
      7:             return CH_PLUS;
      8:             return CH_MINUS;
      default:       return 8'($urandom_range(1, 255));
    endcase
  endfunction

  function automatic logic [7:0] pick_sb();
    return $urandom_range(0, 1) ? CH_S : CH_B;
  endfunction

  // one string of plain runs, line controls, color sequences and broken sequences
  task automatic send_random_string();
    logic [7:0] seq[$];
    logic [7:0] c;
    int         tokens;
    int         kind;
    int         t;
    tokens = $urandom_range(1, 4);
    t = 0;
    while (t < tokens) begin
      kind = $urandom_range(0, 99);
      if (kind < 30) begin
        repeat ($urandom_range(1, 5)) seq.push_back(8'($urandom_range(1, 255)));
      end else if (kind < 42) begin
        seq.push_back($urandom_range(0, 1) ? CH_LF : CH_CR);
      end else if (kind < 80) begin
        seq.push_back(pick_sb());
        seq.push_back(CH_C);
        repeat (6) seq.push_back(field_char());
      end else if (kind < 90) begin
        // sequence start not followed by C, sometimes another start
        seq.push_back(pick_sb());
        c = $urandom_range(0, 2) == 0 ? pick_sb() : 8'($urandom_range(1, 255));
        if (c == CH_C) c = CH_S;
        seq.push_back(c);
      end else begin
        // string ends inside a sequence
        seq.push_back(pick_sb());
        seq.push_back(CH_C);
        repeat ($urandom_range(0, 5)) seq.push_back(field_char());
        t = tokens;
      end
      t++;
    end
    for (int k = 0; k < seq.size(); k++) send_char(seq[k], k == seq.size() - 1);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed: byte extremes, line controls, both color kinds, broken and early-ended sequences
    send_char(8'h01, 1'b0);
    send_char(8'hFF, 1'b1);
    send_text("\n\r");
    send_text("SC12-5 7");
    send_text("BC+3\t999");
    send_text("BQ");
    send_text("S");
    send_text("SC7");

    while (n_sent < 100) send_random_string();

    // stretch with no idling on either side
    calm <= 1'b1;
    while (n_sent < 160) send_random_string();
    calm <= 1'b0;

    // hold off until every pending result has been taken
    wait_drained();

    while (n_sent < 270) send_random_string();

    wait_drained();
    repeat (20) @(posedge clk);
    if ((fail_count == 0) && (pending == 0)) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### files.f
sv/tcep_pkg.sv
sv/tcep_ctrl.sv
sv/tcep_datapath.sv
sv/text_cursor_escape_parser_unit.sv
tb/tcep_checker.sv
tb/tb_top.sv
